@@ sv/bdasc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdasc_pkg
// Shared widths, constants and types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bdasc_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 6;
  localparam int VALUE_BITS_DEF = 32;
  localparam int BCD_DIG_W      = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

  typedef logic [BCD_DIG_W-1:0] bcd_digit_t;

  // Commands from the sequencer to the double dabble core.
  typedef struct packed {
    logic load;
    logic shift;
  } bdasc_cmd_t;

  // Status from the double dabble core back to the sequencer.
  typedef struct packed {
    logic       busy;
    bcd_digit_t top_digit;
  } bdasc_stat_t;

  // Decimal digits of 2^bits - 1, that is floor(bits * log10(2)) + 1.
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

@@ sv/bdasc_if.sv @@
// ----------------------------------------------------------------------------
// bdasc_in_if / bdasc_out_if
// Valid/ready channels for the binary value input and the character output.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdasc_in_if import bdasc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdasc_out_if import bdasc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

@@ sv/bdasc_dabble.sv @@
// ----------------------------------------------------------------------------
// bdasc_dabble
// Bit-serial double dabble core; also shifts the BCD result out by digits.
// ----------------------------------------------------------------------------
`default_nettype none

module bdasc_dabble import bdasc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NDIG       = dec_digits(VALUE_BITS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bdasc_cmd_t            cmd,
  input  wire logic [VALUE_BITS-1:0] value_in,
  output      bdasc_stat_t           stat
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int BCD_W = NDIG * BCD_DIG_W;

  logic [VALUE_BITS-1:0] sh_r,   sh_nxt;
  logic [BCD_W-1:0]      bcd_r,  bcd_nxt;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic                  busy_r, busy_nxt;

  // Add three to every digit of five or more before the next doubling.
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      adj[d*BCD_DIG_W +: BCD_DIG_W] =
        (bcd_r[d*BCD_DIG_W +: BCD_DIG_W] >= 4'd5) ?
        bcd_r[d*BCD_DIG_W +: BCD_DIG_W] + 4'd3 : bcd_r[d*BCD_DIG_W +: BCD_DIG_W];
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.load) begin
      sh_nxt   = value_in;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], sh_r[VALUE_BITS-1]};
      sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_r[BCD_W-BCD_DIG_W-1:0], {BCD_DIG_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.top_digit = bcd_r[BCD_W-1 -: BCD_DIG_W];

endmodule

`default_nettype wire

@@ sv/binary_to_decimal_ascii.sv @@
// Sequence: after the accepting edge, double dabble runs (one input bit per cycle),
// the conversion ends, suppressed leading zeros are dropped one at a time, then one
// digit per cycle goes into the output register while the output is not stalled.
// A new value is accepted only once the last digit of the previous one is loaded.
// Reset: rst_n (synchronous, active low) clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to ASCII decimal digits, most significant
// first, with leading zeros suppressed and the last digit marked.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii import bdasc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdasc_in_if.sink    in_ch,
  bdasc_out_if.source out_ch
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int REM_W = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state_r,  state_nxt;
  logic [REM_W-1:0]      rem_r,    rem_nxt;
  logic                  oval_r,   oval_nxt;
  logic [CHAR_W-1:0]     char_r,   char_nxt;
  logic                  last_r,   last_nxt;
  logic [VALUE_BITS-1:0] value_ext;
  logic                  out_load;
  bdasc_cmd_t            cmd;
  bdasc_stat_t           stat;

  generate
    if (VALUE_BITS <= VALUE_W) begin : g_trunc
      assign value_ext = in_ch.value[VALUE_BITS-1:0];
    end else begin : g_ext
      assign value_ext = {{(VALUE_BITS - VALUE_W){1'b0}}, in_ch.value};
    end
  endgenerate

  bdasc_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .value_in (value_ext),
    .stat     (stat)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_load    = (state_r == ST_EMIT) && (!oval_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cmd       = '0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    oval_nxt  = out_ch.ready ? 1'b0 : oval_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!stat.busy) begin
          rem_nxt   = REM_W'(NDIG);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the final digit.
        if ((stat.top_digit == '0) && (rem_r != REM_W'(1))) begin
          cmd.shift = 1'b1;
          rem_nxt   = rem_r - REM_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          oval_nxt  = 1'b1;
          char_nxt  = CHAR_ZERO + {{(CHAR_W - BCD_DIG_W){1'b0}}, stat.top_digit};
          last_nxt  = (rem_r == REM_W'(1));
          cmd.shift = 1'b1;
          rem_nxt   = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid      = oval_r;
  assign out_ch.digit_char = char_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

@@ sv/bdasc_checker.sv @@
// ----------------------------------------------------------------------------
// bdasc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdasc_checker import bdasc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] out_digit_char,
  input wire logic              out_last
);

  logic [1:0] pend_r;
  logic       first_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests taken whose last digit has not been delivered yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      first_r <= 1'b1;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc && out_last};
      if (out_acc) begin
        first_r <= out_last;
      end
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_digit_char) && $stable(out_last))
    else $error("output payload changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= CHAR_ZERO) && (out_digit_char <= CHAR_ZERO + 6'd9))
    else $error("output character is not a decimal digit");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r && !out_last |-> out_digit_char != CHAR_ZERO)
    else $error("leading zero emitted");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd0 |-> !out_valid)
    else $error("digit emitted without a pending request");

endmodule

bind binary_to_decimal_ascii bdasc_checker u_bdasc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_digit_char (out_ch.digit_char),
  .out_last       (out_ch.last)
);

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks binary_to_decimal_ascii by converting 32-bit values to their decimal
// text in the testbench and comparing each character and end marker that the
// converter delivers.
// ----------------------------------------------------------------------------
module testbench;
  import bdasc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_VALUES = 360;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;

  // Expected characters of every accepted value, oldest first.
  class digit_scoreboard;
    typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
    } char_t;

    char_t       owed_q[$];
    int unsigned mismatches;
    int unsigned values_noted;
    int unsigned chars_checked;
    int unsigned len_seen[1:10];

    function new();
      mismatches    = 0;
      values_noted  = 0;
      chars_checked = 0;
      foreach (len_seen[n]) len_seen[n] = 0;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    // Splits the value into decimal digits, least significant first, then
    // queues them most significant first with the end marker on the last.
    function void note_value(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [3:0]         rev[10];
      int                 n;
      int                 k;
      char_t              c;
      rest = value;
      n = 0;
      do begin
        rev[n] = 4'(rest % 10);
        rest   = rest / 10;
        n++;
      end while (rest != 0);
      for (k = n - 1; k >= 0; k--) begin
        c.digit_char = CHAR_ZERO + CHAR_W'(rev[k]);
        c.last       = (k == 0);
        owed_q.push_back(c);
      end
      len_seen[n]++;
      values_noted++;
    endfunction

    function void flag(input string what, input char_t want, input char_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("ERROR: %s: expected char %0d last %0b, got char %0d last %0b",
                 what, want.digit_char, want.last, got.digit_char, got.last);
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] digit_char, input logic last);
      char_t want;
      char_t got;
      got.digit_char = digit_char;
      got.last       = last;
      chars_checked++;
      if (owed_q.size() == 0) begin
        want = '0;
        flag("character with no request outstanding", want, got);
      end else begin
        want = owed_q.pop_front();
        if (got.digit_char !== want.digit_char || got.last !== want.last) begin
          flag($sformatf("character %0d differs", chars_checked), want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;

  bdasc_in_if  in_ch ();
  bdasc_out_if out_ch ();

  digit_scoreboard board = new();

  binary_to_decimal_ascii u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d characters outstanding",
               cycles, board.owed());
      $display("FAILURE");
      $finish;
    end
  end

  // Character sink: random stalls, one calm stretch and one long hold-off
  // that backs the converter up into its input.
  initial begin : char_sink
    int stall;
    int got;
    bit held;
    got  = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && got == 300) begin
        held  = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else if (got >= 600 && got < 800) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      board.check_char(out_ch.digit_char, out_ch.last);
      got++;
    end
  end

  initial begin : value_source
    logic [VALUE_W-1:0] stim_q[$];
    longint unsigned    span;
    int                 gap;
    int                 i;
    int                 lengths;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;

    // Zero, digit-count boundaries, all ones, alternating bits and the top bit.
    stim_q = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
               32'd100000, 32'd999999999, 32'd1000000000, 32'd1234567890,
               32'd4000000000, 32'd4294967290, 32'd4294967294, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

    for (i = 0; i < RANDOM_VALUES; i++) begin
      span = 1;
      repeat ($urandom_range(1, 10)) span *= 10;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: stim_q.push_back($urandom());
        4, 5, 6, 7: stim_q.push_back(VALUE_W'($urandom() % span));
        8:          stim_q.push_back(VALUE_W'($urandom_range(0, 20)));
        default:    stim_q.push_back(VALUE_W'(span - 1 + $urandom_range(0, 2)));
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < stim_q.size(); i++) begin
      gap = (i >= 150 && i < 200) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        in_ch.value <= $urandom();
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.value <= stim_q[i];
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      board.note_value(stim_q[i]);
    end
    in_ch.valid <= 1'b0;

    while (board.owed() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    lengths = 0;
    foreach (board.len_seen[n]) if (board.len_seen[n] != 0) lengths++;
    $display("Converted %0d values into %0d characters, %0d mismatching.",
             board.values_noted, board.chars_checked, board.mismatches);
    $display("Numbers of %0d distinct digit counts were seen, with one %0d-cycle sink stall.",
             lengths, HOLD_OFF_CYCLES);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ binary_to_decimal_ascii.f @@
sv/bdasc_pkg.sv
sv/bdasc_if.sv
sv/bdasc_dabble.sv
sv/binary_to_decimal_ascii.sv
sv/bdasc_checker.sv
sim/testbench.sv
